### hw/rtl/msqel_pkg.sv
// Shared types and constants for the multi-server queue event list.
`default_nettype none
package msqel_pkg;

    localparam int SIDX_W = 6;
    localparam int TIME_W = 32;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_DEPART  = 1'b1;

    localparam logic CFG_SERVERS = 1'b0;
    localparam logic CFG_START   = 1'b1;

    localparam logic [6:0]  SERVERS_RESET = 7'd24;
    localparam logic [31:0] START_RESET   = 32'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_UPDATE,
        S_SCAN,
        S_DRAIN,
        S_TAKE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              found;
        logic [SIDX_W-1:0] idx;
        logic [TIME_W-1:0] stamp;
    } t_best;

endpackage
`default_nettype wire

### hw/rtl/msqel_if.sv
// Valid/ready channel interfaces for event beats and result beats.
`default_nettype none
interface msqel_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] arrival_time;
    logic [31:0] service_time;

    modport source (output valid, output func, output arrival_time, output service_time,
                    input ready);
    modport sink (input valid, input func, input arrival_time, input service_time,
                  output ready);
endinterface

interface msqel_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] event_time;
    logic [5:0]  server_index;
    logic        server_used;
    logic [31:0] next_departure_time;
    logic        next_departure_valid;
    logic [15:0] jobs_in_node;
    logic [31:0] completed_jobs;
    logic [63:0] time_area;
    logic        bad_departure;

    modport source (output valid, output event_time, output server_index,
                    output server_used, output next_departure_time,
                    output next_departure_valid, output jobs_in_node,
                    output completed_jobs, output time_area, output bad_departure,
                    input ready);
    modport sink (input valid, input event_time, input server_index,
                  input server_used, input next_departure_time,
                  input next_departure_valid, input jobs_in_node,
                  input completed_jobs, input time_area, input bad_departure,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/msqel_stamp_mem.sv
// Server stamp memory with per-entry valid bits that read as the start time.
`default_nettype none
module msqel_stamp_mem #(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear,
    input  wire logic [31:0]   i_reset_val,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : i_reset_val;
endmodule
`default_nettype wire

### hw/rtl/msqel_scan.sv
// Running minimum tracker that the sequencer feeds one server entry per cycle.
`default_nettype none
module msqel_scan #(
    parameter int IW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_cand,
    input  wire logic [IW-1:0] i_idx,
    input  wire logic [31:0]   i_stamp,
    output msqel_pkg::t_best   o_best
);
    import msqel_pkg::*;

    t_best r_best;

    // Strict compare in ascending order keeps the lowest index on ties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_best.found <= 1'b0;
        end else if (i_cand && (!r_best.found || i_stamp < r_best.stamp)) begin
            r_best.found <= 1'b1;
            r_best.idx   <= SIDX_W'(i_idx);
            r_best.stamp <= i_stamp;
        end
    end

    assign o_best = r_best;
endmodule
`default_nettype wire

### hw/rtl/multi_server_queue_event_list.sv
// Top level of the multi-server queue event list: sequencer and datapath.
//
// Events arrive as beats on i_in (func 0 arrival, 1 departure); each event
// gives exactly one result beat on o_out. The configuration port writes
// servers_in_use (index 0) or start_time (index 1); writing start_time
// restarts the node as a reset does. Write it only while the block is idle.
// A small sequencer drives one compare unit over the server stamp memory,
// one entry per cycle; a scan covers the m servers in use.
// An arrival that may start a server scans for the longest-idle server and
// then for the next departure; an arrival that finds every server needed
// skips the first scan. A departure scans for the busy server with the
// earliest stamp, updates the node and that server, then scans for the
// next departure; when none is busy it goes straight to that scan.
// i_in is ready again in the cycle after the result is loaded, so a new
// event is taken only once the result of the last one is loaded. The
// result sits in an output register, so a stalled receiver holds only the
// final step of the next event. Reset clears all servers to idle at the
// start time, the counters to zero, and the server count to 24.
`default_nettype none
module multi_server_queue_event_list #(
    parameter int NUM_SERVERS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    msqel_in_if.sink         i_in,
    msqel_out_if.source      o_out
);
    import msqel_pkg::*;

    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam logic [6:0] M_MAX = 7'(NUM_SERVERS);

    t_state r_state;
    t_state n_state;

    logic [6:0]             r_servers;
    logic [31:0]            r_start;
    logic [NUM_SERVERS-1:0] r_busy;
    logic [31:0]            r_clock;
    logic [15:0]            r_jobs;
    logic [31:0]            r_done;
    logic [63:0]            r_area;
    logic                   r_func;
    logic [31:0]            r_svc;
    logic [31:0]            r_target;
    logic [6:0]             r_m;
    logic [47:0]            r_prod;
    logic                   r_want_busy;
    logic                   n_want_busy;
    logic                   r_phase_next;
    logic                   n_phase_next;
    logic [IW-1:0]          r_scan_cnt;
    logic                   r_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;
    logic [IW-1:0]          r_sel_idx;
    logic [5:0]             r_res_idx;
    logic                   r_res_used;
    logic                   r_res_bad;

    logic                   r_out_valid;
    logic [31:0]            r_out_time;
    logic [5:0]             r_out_idx;
    logic                   r_out_used;
    logic [31:0]            r_out_next;
    logic                   r_out_next_vld;
    logic [15:0]            r_out_jobs;
    logic [31:0]            r_out_done;
    logic [63:0]            r_out_area;
    logic                   r_out_bad;

    logic        in_acc;
    logic        scan_start;
    logic        scan_last;
    logic        restart;
    logic        out_load;
    logic [6:0]  m_clamped;
    logic [15:0] jobs_inc;
    logic [15:0] jobs_dec;
    logic [32:0] finish_sum;
    logic [31:0] finish;
    logic [31:0] delta;
    logic [64:0] area_sum;
    logic        cand;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0] mem_rdata;
    t_best       best;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign restart    = i_cfg_we && (i_cfg_idx == CFG_START);

    assign m_clamped = (r_servers == 7'd0) ? 7'd1 :
                       (r_servers > M_MAX) ? M_MAX : r_servers;
    assign scan_last = (7'(r_scan_cnt) == r_m - 7'd1);
    assign jobs_inc  = (r_jobs != 16'hFFFF) ? r_jobs + 16'd1 : r_jobs;
    assign jobs_dec  = (r_jobs != 16'd0) ? r_jobs - 16'd1 : r_jobs;
    assign finish_sum = {1'b0, r_clock} + {1'b0, r_svc};
    assign finish    = finish_sum[32] ? 32'hFFFF_FFFF : finish_sum[31:0];
    assign delta     = (r_target > r_clock) ? r_target - r_clock : 32'd0;
    assign area_sum  = {1'b0, r_area} + 65'(r_prod);
    assign cand      = r_cmp_vld && (r_busy[r_cmp_idx] == r_want_busy);
    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sel_idx;
        if (r_state == S_TAKE && !r_phase_next && r_func == FUNC_ARRIVAL && best.found) begin
            mem_we    = 1'b1;
            mem_waddr = best.idx[IW-1:0];
        end else if (r_state == S_UPDATE && r_jobs >= 16'(r_m)) begin
            mem_we = 1'b1;
        end
    end

    msqel_stamp_mem #(
        .DEPTH (NUM_SERVERS),
        .AW    (IW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (restart),
        .i_reset_val (r_start),
        .i_we        (mem_we),
        .i_waddr     (mem_waddr),
        .i_wdata     (finish),
        .i_raddr     (r_scan_cnt),
        .o_rdata     (mem_rdata)
    );

    msqel_scan #(
        .IW (IW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_cand  (cand),
        .i_idx   (r_cmp_idx),
        .i_stamp (mem_rdata),
        .o_best  (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_want_busy  = r_want_busy;
        n_phase_next = r_phase_next;
        scan_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.func == FUNC_ARRIVAL) begin
                        n_state = S_MUL;
                    end else begin
                        n_state      = S_SCAN;
                        scan_start   = 1'b1;
                        n_want_busy  = 1'b1;
                        n_phase_next = 1'b0;
                    end
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_func == FUNC_ARRIVAL) begin
                    n_state    = S_SCAN;
                    scan_start = 1'b1;
                    if (jobs_inc <= 16'(r_m)) begin
                        n_want_busy  = 1'b0;
                        n_phase_next = 1'b0;
                    end else begin
                        n_want_busy  = 1'b1;
                        n_phase_next = 1'b1;
                    end
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state      = S_SCAN;
                scan_start   = 1'b1;
                n_want_busy  = 1'b1;
                n_phase_next = 1'b1;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_TAKE;
            end
            S_TAKE: begin
                if (r_phase_next) begin
                    n_state = S_FINISH;
                end else if (r_func == FUNC_ARRIVAL || !best.found) begin
                    n_state      = S_SCAN;
                    scan_start   = 1'b1;
                    n_want_busy  = 1'b1;
                    n_phase_next = 1'b1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servers <= SERVERS_RESET;
            r_start   <= START_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SERVERS) begin
                r_servers <= i_cfg_data[6:0];
            end else begin
                r_start <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_clock <= START_RESET;
            r_jobs  <= '0;
            r_done  <= '0;
            r_area  <= '0;
        end else if (restart) begin
            r_busy  <= '0;
            r_clock <= i_cfg_data;
            r_jobs  <= '0;
            r_done  <= '0;
            r_area  <= '0;
        end else begin
            case (r_state)
                S_ADD: begin
                    r_area  <= area_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : area_sum[63:0];
                    r_clock <= r_target;
                    if (r_func == FUNC_ARRIVAL) begin
                        r_jobs <= jobs_inc;
                    end else begin
                        r_jobs <= jobs_dec;
                        if (r_done != 32'hFFFF_FFFF) begin
                            r_done <= r_done + 32'd1;
                        end
                    end
                end
                S_TAKE: begin
                    if (mem_we) begin
                        r_busy[mem_waddr] <= 1'b1;
                    end
                end
                S_UPDATE: begin
                    if (r_jobs < 16'(r_m)) begin
                        r_busy[r_sel_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_want_busy  <= 1'b0;
            r_phase_next <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_scan_cnt   <= '0;
        end else begin
            r_want_busy  <= n_want_busy;
            r_phase_next <= n_phase_next;
            r_cmp_vld    <= (r_state == S_SCAN);
            if (scan_start) begin
                r_scan_cnt <= '0;
            end else if (r_state == S_SCAN && !scan_last) begin
                r_scan_cnt <= r_scan_cnt + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_cnt;
        if (in_acc) begin
            r_func     <= i_in.func;
            r_svc      <= i_in.service_time;
            r_target   <= i_in.arrival_time;
            r_m        <= m_clamped;
            r_res_idx  <= '0;
            r_res_used <= 1'b0;
            r_res_bad  <= 1'b0;
        end
        if (r_state == S_MUL) begin
            r_prod <= 48'(delta) * 48'(r_jobs);
        end
        if (r_state == S_TAKE && !r_phase_next) begin
            if (best.found) begin
                r_sel_idx  <= best.idx[IW-1:0];
                r_target   <= best.stamp;
                r_res_idx  <= best.idx;
                r_res_used <= 1'b1;
            end else if (r_func == FUNC_DEPART) begin
                r_res_bad <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_time     <= r_clock;
            r_out_idx      <= r_res_idx;
            r_out_used     <= r_res_used;
            r_out_next     <= best.found ? best.stamp : 32'd0;
            r_out_next_vld <= best.found;
            r_out_jobs     <= r_jobs;
            r_out_done     <= r_done;
            r_out_area     <= r_area;
            r_out_bad      <= r_res_bad;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.event_time           = r_out_time;
    assign o_out.server_index         = r_out_idx;
    assign o_out.server_used          = r_out_used;
    assign o_out.next_departure_time  = r_out_next;
    assign o_out.next_departure_valid = r_out_next_vld;
    assign o_out.jobs_in_node         = r_out_jobs;
    assign o_out.completed_jobs       = r_out_done;
    assign o_out.time_area            = r_out_area;
    assign o_out.bad_departure        = r_out_bad;
endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the multi-server queue event list.
`timescale 1ns / 1ps
module tb_top;
    import msqel_pkg::*;

    localparam int NSRV          = 24;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_BEATS   = 140;

    typedef struct {
        logic [31:0] event_time;
        logic [5:0]  server_index;
        logic        server_used;
        logic [31:0] next_departure_time;
        logic        next_departure_valid;
        logic [15:0] jobs_in_node;
        logic [31:0] completed_jobs;
        logic [63:0] time_area;
        logic        bad_departure;
    } t_event_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    msqel_in_if  in_ch ();
    msqel_out_if out_ch ();

    multi_server_queue_event_list #(
        .NUM_SERVERS(NSRV)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Model of the node as the testbench sees it.
    logic [6:0]  cfg_servers;
    logic [31:0] cfg_start;
    bit          srv_busy [NSRV];
    logic [31:0] srv_stamp [NSRV];
    logic [31:0] node_clock;
    logic [15:0] node_jobs;
    logic [31:0] node_done;
    logic [63:0] node_area;

    t_event_result pending_results [$];
    int  fail_count;
    int  in_gap;
    bit  src_quiet;
    bit  sink_quiet;
    bit  sink_hold_req;
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_node();
        for (int i = 0; i < NSRV; i++) begin
            srv_busy[i]  = 1'b0;
            srv_stamp[i] = cfg_start;
        end
        node_clock = cfg_start;
        node_jobs  = '0;
        node_done  = '0;
        node_area  = '0;
    endfunction

    function automatic int servers_active();
        int m;
        m = cfg_servers;
        if (m < 1) m = 1;
        if (m > NSRV) m = NSRV;
        return m;
    endfunction

    // Lowest stamp among servers in the wanted state; the lowest index wins ties.
    function automatic int scan_servers(int m, bit want_busy);
        int best;
        best = -1;
        for (int i = 0; i < m; i++) begin
            if (srv_busy[i] == want_busy && (best < 0 || srv_stamp[i] < srv_stamp[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic logic [31:0] finish_time(logic [31:0] svc);
        logic [32:0] f;
        f = {1'b0, node_clock} + {1'b0, svc};
        return f[32] ? 32'hFFFF_FFFF : f[31:0];
    endfunction

    function automatic void advance_clock(logic [31:0] t);
        logic [63:0] span;
        logic [63:0] add;
        logic [64:0] sum;
        if (t > node_clock) begin
            span = 64'(t) - 64'(node_clock);
            add  = span * {48'b0, node_jobs};
            sum  = {1'b0, node_area} + {1'b0, add};
            node_area = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
        end
        node_clock = t;
    endfunction

    function automatic t_event_result predict_event(logic f, logic [31:0] at,
                                                    logic [31:0] svc);
        t_event_result r;
        int m;
        int s;
        r = '{default: '0};
        m = servers_active();
        if (f == FUNC_ARRIVAL) begin
            advance_clock(at);
            if (node_jobs != 16'hFFFF) node_jobs++;
            if (int'(node_jobs) <= m) begin
                s = scan_servers(m, 1'b0);
                if (s >= 0) begin
                    srv_busy[s]    = 1'b1;
                    srv_stamp[s]   = finish_time(svc);
                    r.server_index = 6'(s);
                    r.server_used  = 1'b1;
                end
            end
        end else begin
            s = scan_servers(m, 1'b1);
            if (s < 0) begin
                r.bad_departure = 1'b1;
            end else begin
                advance_clock(srv_stamp[s]);
                if (node_jobs != 0) node_jobs--;
                if (node_done != 32'hFFFF_FFFF) node_done++;
                if (int'(node_jobs) >= m)
                    srv_stamp[s] = finish_time(svc);
                else
                    srv_busy[s] = 1'b0;
                r.server_index = 6'(s);
                r.server_used  = 1'b1;
            end
        end
        s = scan_servers(m, 1'b1);
        r.event_time           = node_clock;
        r.next_departure_valid = (s >= 0);
        r.next_departure_time  = (s >= 0) ? srv_stamp[s] : 32'd0;
        r.jobs_in_node         = node_jobs;
        r.completed_jobs       = node_done;
        r.time_area            = node_area;
        return r;
    endfunction

    task automatic send_event(logic f, logic [31:0] at, logic [31:0] svc);
        repeat (in_gap) @(posedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.func         <= f;
        in_ch.arrival_time <= at;
        in_ch.service_time <= svc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_event(f, at, svc));
        in_gap = src_quiet ? 0 : $urandom_range(0, 11);
        if (in_gap != 0) in_ch.valid <= 1'b0;
    endtask

    task automatic stop_input();
        if (in_gap == 0) in_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        stop_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SERVERS) begin
            cfg_servers = data[6:0];
        end else begin
            cfg_start = data;
            restart_node();
        end
    endtask

    // Mostly well-formed events that follow the node clock, with some noise.
    task automatic random_event();
        logic        f;
        logic [31:0] at;
        logic [31:0] svc;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            f   = $urandom_range(0, 1);
            at  = $urandom;
            svc = $urandom;
        end else begin
            f  = ($urandom_range(0, 99) < 52) ? FUNC_ARRIVAL : FUNC_DEPART;
            at = node_clock + $urandom_range(0, 40);
            if (r < 10) at = node_clock - $urandom_range(1, 100);
            if (f == FUNC_DEPART) at = $urandom;
            r = $urandom_range(0, 99);
            if (r < 4)
                svc = $urandom;
            else if (r < 6)
                svc = 32'd0;
            else
                svc = $urandom_range(1, 300);
        end
        send_event(f, at, svc);
    endtask

    task automatic check_result();
        t_event_result got;
        t_event_result want;
        got.event_time           = out_ch.event_time;
        got.server_index         = out_ch.server_index;
        got.server_used          = out_ch.server_used;
        got.next_departure_time  = out_ch.next_departure_time;
        got.next_departure_valid = out_ch.next_departure_valid;
        got.jobs_in_node         = out_ch.jobs_in_node;
        got.completed_jobs       = out_ch.completed_jobs;
        got.time_area            = out_ch.time_area;
        got.bad_departure        = out_ch.bad_departure;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("%t: result beat with nothing expected", $realtime);
            return;
        end
        want = pending_results.pop_front();
        if (got.event_time !== want.event_time ||
            got.server_index !== want.server_index ||
            got.server_used !== want.server_used ||
            got.next_departure_time !== want.next_departure_time ||
            got.next_departure_valid !== want.next_departure_valid ||
            got.jobs_in_node !== want.jobs_in_node ||
            got.completed_jobs !== want.completed_jobs ||
            got.time_area !== want.time_area ||
            got.bad_departure !== want.bad_departure) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("%t: result mismatch", $realtime);
                $display("  exp t=%h idx=%0d used=%b nxt=%h/%b jobs=%0d done=%0d area=%h bad=%b",
                         want.event_time, want.server_index, want.server_used,
                         want.next_departure_time, want.next_departure_valid,
                         want.jobs_in_node, want.completed_jobs, want.time_area,
                         want.bad_departure);
                $display("  got t=%h idx=%0d used=%b nxt=%h/%b jobs=%0d done=%0d area=%h bad=%b",
                         got.event_time, got.server_index, got.server_used,
                         got.next_departure_time, got.next_departure_valid,
                         got.jobs_in_node, got.completed_jobs, got.time_area,
                         got.bad_departure);
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                check_result();
                if (sink_hold_req) begin
                    stall = HOLD_CYCLES;
                    sink_hold_req = 1'b0;
                end else begin
                    stall = sink_quiet ? 0 : $urandom_range(0, 11);
                end
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_empty_and_extremes();
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        send_event(FUNC_ARRIVAL, 32'd0, 32'd0);
        send_event(FUNC_ARRIVAL, 32'd0, 32'd0);
        send_event(FUNC_DEPART, 32'd0, 32'd5);
        send_event(FUNC_ARRIVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(FUNC_ARRIVAL, 32'd5, 32'd100);
        send_event(FUNC_DEPART, 32'hFFFF_FFFF, 32'd7);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        settle();
    endtask

    task automatic test_server_count();
        write_reg(CFG_SERVERS, 32'd1);
        send_event(FUNC_ARRIVAL, 32'd10, 32'd20);
        send_event(FUNC_ARRIVAL, 32'd12, 32'd5);
        send_event(FUNC_DEPART, 32'd0, 32'd30);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        settle();
        write_reg(CFG_SERVERS, 32'd0);
        send_event(FUNC_ARRIVAL, 32'd40, 32'd3);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        settle();
    endtask

    task automatic test_start_time();
        write_reg(CFG_SERVERS, 32'd24);
        write_reg(CFG_START, 32'hFFFF_FF00);
        send_event(FUNC_ARRIVAL, 32'hFFFF_FF10, 32'h10);
        send_event(FUNC_ARRIVAL, 32'hFFFF_FF20, 32'h400);
        send_event(FUNC_ARRIVAL, 32'hFFFF_FF30, 32'h20);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        settle();
        // Servers 1 and 2 stay busy beyond the server count and are frozen.
        write_reg(CFG_SERVERS, 32'd1);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        send_event(FUNC_ARRIVAL, 32'hFFFF_FF60, 32'd1);
        settle();
        write_reg(CFG_START, 32'hFFFF_FFFF);
        send_event(FUNC_ARRIVAL, 32'd0, 32'd3);
        send_event(FUNC_DEPART, 32'd0, 32'd0);
        settle();
    endtask

    task automatic test_random();
        int          servers [7];
        logic [31:0] start;
        servers = '{1, 3, 24, 64, 0, 127, 0};
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) servers[ph] = $urandom_range(1, NSRV);
            case (ph % 3)
                0: start = 32'd0;
                1: start = $urandom;
                default: start = 32'hFFFF_F000;
            endcase
            write_reg(CFG_SERVERS, 32'(servers[ph]));
            write_reg(CFG_START, start);
            src_quiet  = (ph % 3 == 1);
            sink_quiet = (ph % 3 == 2);
            for (int n = 0; n < PHASE_BEATS; n++) random_event();
            settle();
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_SERVERS, 32'd2);
        write_reg(CFG_START, 32'd100);
        src_quiet     = 1'b1;
        sink_hold_req = 1'b1;
        for (int n = 0; n < 12; n++) random_event();
        settle();
        src_quiet = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_SERVERS;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_ARRIVAL;
        in_ch.arrival_time = '0;
        in_ch.service_time = '0;
        fail_count         = 0;
        in_gap             = 0;
        src_quiet          = 1'b0;
        sink_quiet         = 1'b0;
        sink_hold_req      = 1'b0;
        idle_cycles        = 0;
        cfg_servers        = SERVERS_RESET;
        cfg_start          = START_RESET;
        restart_node();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_extremes();
        test_server_count();
        test_start_time();
        test_random();
        test_backpressure();

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hw/rtl/msqel_pkg.sv
hw/rtl/msqel_if.sv
hw/rtl/msqel_stamp_mem.sv
hw/rtl/msqel_scan.sv
hw/rtl/multi_server_queue_event_list.sv
sim/tb_top.sv
